FILE: design/linked_mailbox_queue_engine_defines.svh
`ifndef LINKED_MAILBOX_QUEUE_ENGINE_DEFINES_SVH
`define LINKED_MAILBOX_QUEUE_ENGINE_DEFINES_SVH

// condition checked at every clock edge outside reset
`define LMQ_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lmq check failed");

// consequent checked in the cycle of the antecedent
`define LMQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmq check failed");

`endif

FILE: design/lmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmq_pkg;

   localparam int OPCODE_W = 1;
   localparam int RANK_W   = 4;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;
   localparam int PC_W     = 5;
   localparam int LIMIT_W  = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [OPCODE_W-1:0] OP_SEND = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_RECV = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_LONG  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANK  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_RANK_LIMIT = 1'b1;

   localparam logic [PC_W-1:0]    PROCESS_COUNT_RESET  = 5'd16;
   localparam logic [LIMIT_W-1:0] PER_RANK_LIMIT_RESET = 9'd16;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // low n bytes set, all bytes for n of eight or more
   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int b = 0; b < DATA_W / 8; b++) begin
         if (LEN_W'(b) < n) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: design/lmq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

`default_nettype wire

FILE: design/linked_mailbox_queue_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linked_mailbox_queue_engine_defines.svh"

// Mailbox engine: a pool of SLOTS message slots kept as one linked free list plus one
// linked FIFO per destination rank. A send (opcode 0) takes the free head, stores the
// payload, length and sender, and links the slot behind the destination's tail; a
// receive (opcode 1) pops the caller's head and returns source, stored length and the
// payload cut to the smaller of stored length and buffer size. Exactly one result
// transfer follows every request transfer, with status 0 ok, 1 too long, 2 bad rank,
// 3 no slot or limit reached, 4 no message. One request is worked at a time: a
// successful operation passes from the check state through the update state, which
// writes back the list pointers, to the result state before its result is offered;
// a rejected one skips the update state. The link memory's read is registered: it is
// addressed in the check state and used in the update state, and the result passes
// through the result register. A new request is taken while the previous result still
// waits; a stalled result holds the next one in the result stage until it leaves. After
// reset every entry of the link memory is initialized, during which requests stall;
// configuration writes are taken at any time.
module linked_mailbox_queue_engine
   import lmq_pkg::*;
#(
   parameter int SLOTS         = 256,
   parameter int RANKS         = 16,
   parameter int PAYLOAD_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [RANK_W-1:0]     req_rank,
   input  wire logic [RANK_W-1:0]     req_dest_rank,
   input  wire logic [DATA_W-1:0]     req_data,
   input  wire logic [LEN_W-1:0]      req_length,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [STATUS_W-1:0]   rsp_status,
   output logic      [RANK_W-1:0]     rsp_message_source,
   output logic      [LEN_W-1:0]      rsp_message_length,
   output logic      [DATA_W-1:0]     rsp_message_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam int RW = (RANKS > 1) ? $clog2(RANKS) : 1;
   localparam int DW = 8 * PAYLOAD_BYTES;
   localparam int SW = DW + LEN_W + RANK_W;
   localparam logic [LW-1:0] NIL  = LW'(SLOTS);
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   state_type state_ff, state_in;

   logic [PC_W-1:0]    pc_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic [OPCODE_W-1:0] op_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [RANK_W-1:0]   dest_ff;
   logic [DW-1:0]       data_ff;
   logic [LEN_W-1:0]    len_ff;

   logic [AW-1:0] init_ctr_ff, init_ctr_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] free_tail_ff, free_tail_in;

   logic [LW-1:0]      queue_head_ff  [RANKS];
   logic [LW-1:0]      queue_tail_ff  [RANKS];
   logic [LIMIT_W-1:0] queue_count_ff [RANKS];

   logic [RW-1:0]      qidx;
   logic [LW-1:0]      q_head, q_head_in;
   logic [LW-1:0]      q_tail, q_tail_in;
   logic [LIMIT_W-1:0] q_count, q_count_in;
   logic               q_we;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [RANK_W-1:0]   res_source_ff, res_source_in;
   logic [LEN_W-1:0]    res_length_ff, res_length_in;
   logic [DATA_W-1:0]   res_data_ff, res_data_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [RANK_W-1:0]   rsp_source_ff, rsp_source_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_load;

   logic                req_take;
   logic [DATA_W-1:0]   req_mask;
   logic                rank_good, dest_good, free_empty, q_empty;
   logic [STATUS_W-1:0] check_status;
   logic [AW-1:0]       check_slot;

   logic          link_we;
   logic [AW-1:0] link_wa;
   logic [LW-1:0] link_wd;
   logic [LW-1:0] link_rd;
   logic          slot_we;
   logic [SW-1:0] slot_rd;

   logic [DW-1:0]     slot_payload;
   logic [LEN_W-1:0]  slot_len;
   logic [RANK_W-1:0] slot_src;
   logic [LEN_W-1:0]  take_len;
   logic [DATA_W-1:0] take_mask;

   lmq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
      .clock         (clock),
      .write_enable  (link_we),
      .write_address (link_wa),
      .write_data    (link_wd),
      .read_address  (check_slot),
      .read_data     (link_rd)
   );

   lmq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
      .clock         (clock),
      .write_enable  (slot_we),
      .write_address (check_slot),
      .write_data    ({data_ff, len_ff, rank_ff}),
      .read_address  (check_slot),
      .read_data     (slot_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign req_mask  = byte_mask(req_length);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_message_source = rsp_source_ff;
   assign rsp_message_length = rsp_length_ff;
   assign rsp_message_data   = rsp_data_ff;

   // queue entry of the caller on receive, of the destination on send
   assign qidx    = RW'((op_ff == OP_RECV) ? rank_ff : dest_ff);
   assign q_head  = queue_head_ff[qidx];
   assign q_tail  = queue_tail_ff[qidx];
   assign q_count = queue_count_ff[qidx];

   assign free_empty = (free_head_ff >= NIL);
   assign q_empty    = (q_head >= NIL);
   assign rank_good  = ({1'b0, rank_ff} < pc_ff) && (32'(rank_ff) < RANKS);
   assign dest_good  = ({1'b0, dest_ff} < pc_ff) && (32'(dest_ff) < RANKS);
   assign check_slot = (op_ff == OP_RECV) ? q_head[AW-1:0] : free_head_ff[AW-1:0];

   assign slot_payload = slot_rd[SW-1 -: DW];
   assign slot_len     = slot_rd[RANK_W +: LEN_W];
   assign slot_src     = slot_rd[RANK_W-1:0];
   assign take_len     = (slot_len < len_ff) ? slot_len : len_ff;
   assign take_mask    = byte_mask(take_len);

   always_comb begin
      check_status = STATUS_OK;
      if (op_ff == OP_SEND) begin
         priority if (32'(len_ff) > PAYLOAD_BYTES) begin
            check_status = STATUS_LONG;
         end else if (!rank_good || !dest_good) begin
            check_status = STATUS_RANK;
         end else if ((q_count >= limit_ff) || free_empty) begin
            check_status = STATUS_FULL;
         end else begin
            check_status = STATUS_OK;
         end
      end else begin
         priority if (!rank_good) begin
            check_status = STATUS_RANK;
         end else if (q_empty) begin
            check_status = STATUS_EMPTY;
         end else begin
            check_status = STATUS_OK;
         end
      end
   end

   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_ctr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (check_status == STATUS_OK) ? ST_UPDATE : ST_RESULT;
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      link_we       = 1'b0;
      link_wa       = check_slot;
      link_wd       = NIL;
      slot_we       = 1'b0;
      init_ctr_in   = init_ctr_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      q_we          = 1'b0;
      q_head_in     = q_head;
      q_tail_in     = q_tail;
      q_count_in    = q_count;
      res_status_in = res_status_ff;
      res_source_in = res_source_ff;
      res_length_in = res_length_ff;
      res_data_in   = res_data_ff;
      unique case (state_ff)
         ST_INIT: begin
            link_we     = 1'b1;
            link_wa     = init_ctr_ff;
            link_wd     = LW'(init_ctr_ff) + LW'(1);
            init_ctr_in = init_ctr_ff + AW'(1);
         end
         ST_CHECK: begin
            res_status_in = check_status;
            res_source_in = '0;
            res_length_in = '0;
            res_data_in   = '0;
            if (check_status == STATUS_OK) begin
               // unlink the slot while its old link is read out
               link_we = 1'b1;
               slot_we = (op_ff == OP_SEND);
            end
         end
         ST_UPDATE: begin
            q_we = 1'b1;
            if (op_ff == OP_SEND) begin
               if (link_rd >= NIL) begin
                  free_head_in = NIL;
                  free_tail_in = NIL;
               end else begin
                  free_head_in = link_rd;
               end
               if (q_empty) begin
                  q_head_in = LW'(check_slot);
               end else begin
                  link_we = 1'b1;
                  link_wa = q_tail[AW-1:0];
                  link_wd = LW'(check_slot);
               end
               q_tail_in  = LW'(check_slot);
               q_count_in = q_count + LIMIT_W'(1);
            end else begin
               if (link_rd >= NIL) begin
                  q_head_in = NIL;
                  q_tail_in = NIL;
               end else begin
                  q_head_in = link_rd;
               end
               if (q_count != '0) begin
                  q_count_in = q_count - LIMIT_W'(1);
               end
               res_source_in = slot_src;
               res_length_in = slot_len;
               res_data_in   = DATA_W'(slot_payload & take_mask[DW-1:0]);
               if (free_empty) begin
                  free_head_in = LW'(check_slot);
               end else begin
                  link_we = 1'b1;
                  link_wa = free_tail_ff[AW-1:0];
                  link_wd = LW'(check_slot);
               end
               free_tail_in = LW'(check_slot);
            end
         end
         ST_IDLE, ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
      rsp_source_in = rsp_load ? res_source_ff : rsp_source_ff;
      rsp_length_in = rsp_load ? res_length_ff : rsp_length_ff;
      rsp_data_in   = rsp_load ? res_data_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ctr_ff  <= '0;
         free_head_ff <= '0;
         free_tail_ff <= LW'(SLOTS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ctr_ff  <= init_ctr_in;
         free_head_ff <= free_head_in;
         free_tail_ff <= free_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= PROCESS_COUNT_RESET;
         limit_ff <= PER_RANK_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT:  pc_ff    <= csr_wdata[PC_W-1:0];
            CSR_PER_RANK_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RANKS; i++) begin
            queue_head_ff[i]  <= NIL;
            queue_tail_ff[i]  <= NIL;
            queue_count_ff[i] <= '0;
         end
      end else if (q_we) begin
         queue_head_ff[qidx]  <= q_head_in;
         queue_tail_ff[qidx]  <= q_tail_in;
         queue_count_ff[qidx] <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_opcode;
         rank_ff <= req_rank;
         dest_ff <= req_dest_rank;
         data_ff <= req_data[DW-1:0] & req_mask[DW-1:0];
         len_ff  <= req_length;
      end
      res_status_ff <= res_status_in;
      res_source_ff <= res_source_in;
      res_length_ff <= res_length_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_source_ff <= rsp_source_in;
      rsp_length_ff <= rsp_length_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // free list head and tail go empty together
   `LMQ_ASSERT_HOLDS(a_free_ends, clock, reset, (free_head_ff >= NIL) == (free_tail_ff >= NIL))

   // an empty queue has a zero count and the other way round
   `LMQ_ASSERT_IMPLIES(a_queue_count, clock, reset,
      state_ff == ST_CHECK && rank_good && dest_good, (q_head >= NIL) == (q_count == '0))

   // a failed or send result carries no message
   `LMQ_ASSERT_IMPLIES(a_error_clean, clock, reset,
      rsp_valid && (rsp_status != STATUS_OK || rsp_message_length == '0),
      rsp_message_data == '0)

endmodule

`default_nettype wire
